// ----- rtl/core/lrssm_pkg.sv -----
`default_nettype none

package lrssm_pkg;

  // weight table geometry
  localparam int WeightBits = 27;
  localparam int ValueBits  = 27;
  localparam int StoreBits  = (WeightBits < ValueBits) ? WeightBits : ValueBits;
  localparam int TableSize  = 100;
  localparam int IndexBits  = 7;
  localparam int StepBits   = 2;
  localparam int WordBits   = 32;

  // selection fields of the third and fourth words
  localparam int SelLowBits = 9;
  localparam int SelHighPos = 23;

  localparam logic [IndexBits-1:0] LastAddr = IndexBits'(TableSize - 1);
  localparam logic [StepBits-1:0]  LastStep = StepBits'(3);

  // configuration register indexes
  localparam int CfgIndexBits = 3;
  localparam logic [CfgIndexBits-1:0] RegMultiplier = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegIncrement  = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegShift      = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegTarget     = 3'd3;

  // configuration reset values
  localparam logic [31:0] ResetMultiplier = 32'd1000000009;
  localparam logic [31:0] ResetIncrement  = 32'd1003;
  localparam logic [4:0]  ResetShift      = 5'd12;
  localparam logic [31:0] ResetTarget     = 32'd435939;

  // controller to datapath commands
  typedef struct packed {
    logic                 load_weight;
    logic                 start;
    logic                 mul;
    logic                 add;
    logic [StepBits-1:0]  step;
    logic                 read;
    logic [IndexBits-1:0] rd_addr;
    logic                 load_out;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrssm_ctrl.sv -----
`default_nettype none

module lrssm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           kind,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lrssm_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    IDLE = 6'b000001,
    MUL  = 6'b000010,
    ADD  = 6'b000100,
    SUM  = 6'b001000,
    LAST = 6'b010000,
    CMP  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [lrssm_pkg::StepBits-1:0]  step;
  logic [lrssm_pkg::IndexBits-1:0] rd_addr;

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.step    = step;
    cmd.rd_addr = rd_addr;
    in_ready    = (state == IDLE);
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          if (kind) begin
            cmd.start  = 1'b1;
            state_next = MUL;
          end else begin
            cmd.load_weight = 1'b1;
          end
        end
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = ADD;
      end
      ADD: begin
        cmd.add    = 1'b1;
        state_next = (step == lrssm_pkg::LastStep) ? SUM : MUL;
      end
      SUM: begin
        cmd.read = 1'b1;
        if (rd_addr == lrssm_pkg::LastAddr) state_next = LAST;
      end
      LAST: begin
        state_next = CMP;
      end
      CMP: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // state, step and read counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      step    <= '0;
      rd_addr <= '0;
    end else begin
      state <= state_next;
      if (cmd.add) step <= step + 1'b1;
      if (cmd.read) begin
        rd_addr <= (rd_addr == lrssm_pkg::LastAddr) ? '0 : rd_addr + 1'b1;
      end
    end
  end

  // result word waiting at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_cmp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == CMP && out_valid && !out_ready) |=> (state == CMP))
    else $error("compare state left while output still full");

  a_valid_from_cmp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == CMP))
    else $error("output valid rose outside compare state");

  a_sum_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ADD && step == lrssm_pkg::LastStep) |=> (state == SUM && rd_addr == '0))
    else $error("table sweep did not start at entry zero");

  a_addr_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == SUM) |-> (rd_addr <= lrssm_pkg::LastAddr))
    else $error("read address beyond table");

endmodule

`default_nettype wire

// ----- rtl/core/lrssm_dp.sv -----
`default_nettype none

module lrssm_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lrssm_pkg::cmd_t                   cmd,
  input  wire logic [lrssm_pkg::IndexBits-1:0]   weight_index,
  input  wire logic [lrssm_pkg::ValueBits-1:0]   weight_value,
  input  wire logic                              cfg_write,
  input  wire logic [lrssm_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output logic [31:0]                            word_zero,
  output logic [31:0]                            word_one,
  output logic [31:0]                            word_two,
  output logic [31:0]                            word_three,
  output logic [31:0]                            subset_sum,
  output logic                                   is_match,
  output logic [31:0]                            match_count
);

  logic [31:0] lcg_mul, lcg_inc, target;
  logic [4:0]  shift;
  logic [31:0] gen_state, prod, x_next;
  logic [31:0] words [4];
  logic [lrssm_pkg::TableSize-1:0] sel_vec;
  logic [lrssm_pkg::TableSize-1:0] vld;
  logic [lrssm_pkg::StoreBits-1:0] mem [lrssm_pkg::TableSize];
  logic [lrssm_pkg::StoreBits-1:0] rd_data;
  logic        rd_vld, sel_q, acc_en;
  logic [31:0] acc, hit_total;
  logic        hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_mul <= lrssm_pkg::ResetMultiplier;
      lcg_inc <= lrssm_pkg::ResetIncrement;
      shift   <= lrssm_pkg::ResetShift;
      target  <= lrssm_pkg::ResetTarget;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lrssm_pkg::RegMultiplier: lcg_mul <= cfg_data;
        lrssm_pkg::RegIncrement:  lcg_inc <= cfg_data;
        lrssm_pkg::RegShift:      shift   <= cfg_data[4:0];
        lrssm_pkg::RegTarget:     target  <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight table, write side
  always_ff @(posedge clk) begin
    if (cmd.load_weight && weight_index < lrssm_pkg::IndexBits'(lrssm_pkg::TableSize)) begin
      mem[weight_index] <= weight_value[lrssm_pkg::StoreBits-1:0];
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.load_weight
                 && weight_index < lrssm_pkg::IndexBits'(lrssm_pkg::TableSize)) begin
      vld[weight_index] <= 1'b1;
    end
  end

  // generator: multiply, then add increment
  assign x_next = prod + lcg_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (cmd.add) begin
      gen_state <= x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= lcg_mul * gen_state;
    if (cmd.add) words[cmd.step] <= x_next;
  end

  // subset selection bits in table order
  assign sel_vec = {words[3][31:lrssm_pkg::SelHighPos], words[3][lrssm_pkg::SelLowBits-1:0],
                    words[2][31:lrssm_pkg::SelHighPos], words[2][lrssm_pkg::SelLowBits-1:0],
                    words[1], words[0]};

  // table sweep, read side
  always_ff @(posedge clk) begin
    rd_data <= mem[cmd.rd_addr];
    rd_vld  <= vld[cmd.rd_addr];
    sel_q   <= sel_vec[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.read;
    end
  end

  // accumulate selected weights
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (acc_en && sel_q && rd_vld) begin
      acc <= acc + 32'(rd_data);
    end
  end

  // shifted compare against target
  assign hit = ((acc >> shift) == target);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total <= '0;
    end else if (cmd.load_out && hit) begin
      hit_total <= hit_total + 32'd1;
    end
  end

  assign match_count = hit_total;

  // output word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      word_zero  <= words[0];
      word_one   <= words[1];
      word_two   <= words[2];
      word_three <= words[3];
      subset_sum <= acc;
      is_match   <= hit;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcg_random_subset_sum_matcher.sv -----
// load word: accepted when idle, no output word
// generate word: from accept to out_valid, four generator steps (multiplier,
//   then increment add) and a 100-entry sweep of the single-read-port weight
//   table, then the LAST and CMP states to finish and compare
// a generate word may be accepted again once the previous result is latched and the controller is back in IDLE
// reset: synchronous; table valid bits cleared, configuration registers to defaults
`default_nettype none

module lcg_random_subset_sum_matcher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [lrssm_pkg::IndexBits-1:0]   weight_index,
  input  wire logic [lrssm_pkg::ValueBits-1:0]   weight_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [31:0]                            word_zero,
  output logic [31:0]                            word_one,
  output logic [31:0]                            word_two,
  output logic [31:0]                            word_three,
  output logic [31:0]                            subset_sum,
  output logic                                   is_match,
  output logic [31:0]                            match_count,
  input  wire logic                              cfg_write,
  input  wire logic [lrssm_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  lrssm_pkg::cmd_t cmd;

  // sequencing
  lrssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // generator, table and accumulator
  lrssm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .weight_index (weight_index),
    .weight_value (weight_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word_zero    (word_zero),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .subset_sum   (subset_sum),
    .is_match     (is_match),
    .match_count  (match_count)
  );

endmodule

`default_nettype wire
